>>> src/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// shared constants and types for the sorted min priority queue
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEPTH = 10;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int FILL_W = 4;
    localparam int STATUS_W = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic                load;
        logic                do_push;
        logic                do_pop;
        logic [STATUS_W-1:0] code;
    } smpq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } smpq_stat_t;

endpackage

>>> src/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// fixed-depth queue of signed values kept in descending order; pop gives min
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | kind, push_value
//  out     | out_valid / out_ready| popped_value, status, fill_count
//
//  one beat per cycle while the output is not stalled: on a push every cell
//  compares against the pushed value in parallel and shifts down by one;
//  result appears the cycle after the input beat, held in an output register
//  input is taken while the output beat is being taken in the same cycle
//  reset clears the fill count and the output valid; cell contents stay
// ----------------------------------------------------------------------------
module sorted_min_priority_queue (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   kind,
    input  logic signed [smpq_pkg::DATA_W-1:0]     push_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [smpq_pkg::DATA_W-1:0]     popped_value,
    output logic [smpq_pkg::STATUS_W-1:0]          status,
    output logic [smpq_pkg::FILL_W-1:0]            fill_count
);
    import smpq_pkg::*;

    smpq_cmd_t  cmd;
    smpq_stat_t stat;

    smpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    smpq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .push_value   (push_value),
        .stat         (stat),
        .popped_value (popped_value),
        .status       (status),
        .fill_count   (fill_count)
    );

endmodule

>>> src/smpq_ctrl.sv
// ----------------------------------------------------------------------------
// smpq_ctrl
// handshake control: decides each operation and owns the result register valid
// ----------------------------------------------------------------------------
module smpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    output logic                out_valid,
    input  logic                out_ready,
    input  smpq_pkg::smpq_stat_t stat,
    output smpq_pkg::smpq_cmd_t  cmd
);
    import smpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   exec;

    // result register frees up in the same cycle it is taken
    assign out_valid = (state_reg == S_HOLD);
    assign in_ready  = !out_valid || out_ready;
    assign exec      = in_valid && in_ready;

    always_comb
    begin
        cmd.load    = exec;
        cmd.do_push = exec && (kind == KIND_PUSH) && !stat.full;
        cmd.do_pop  = exec && (kind == KIND_POP) && !stat.empty;
        if (kind == KIND_PUSH)
        begin
            cmd.code = stat.full ? ST_OVERFLOW : ST_OK;
        end
        else
        begin
            cmd.code = stat.empty ? ST_EMPTY : ST_OK;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (exec)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!exec && out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_push && cmd.do_pop))
        else $error("push and pop issued together");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("beat taken but no result shown");

endmodule

>>> src/smpq_dp.sv
// ----------------------------------------------------------------------------
// smpq_dp
// sorted cell array (descending), fill count and result register
// ----------------------------------------------------------------------------
module smpq_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  smpq_pkg::smpq_cmd_t                    cmd,
    input  logic signed [smpq_pkg::DATA_W-1:0]     push_value,
    output smpq_pkg::smpq_stat_t                   stat,
    output logic signed [smpq_pkg::DATA_W-1:0]     popped_value,
    output logic [smpq_pkg::STATUS_W-1:0]          status,
    output logic [smpq_pkg::FILL_W-1:0]            fill_count
);
    import smpq_pkg::*;

    logic signed [DATA_W-1:0] entries_reg [DEPTH];
    logic signed [DATA_W-1:0] entries_next [DEPTH];
    logic [DEPTH-1:0]         keep;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         count_dec;
    logic [IDX_W-1:0]         pop_idx;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [FILL_W-1:0]        fill_reg;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign count_dec  = count_reg - 1'b1;
    assign pop_idx    = count_dec[IDX_W-1:0];

    // a cell keeps its entry when it is live and not below the new value
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) && (entries_reg[i] >= push_value);
        end
    end

    always_comb
    begin
        entries_next[0] = keep[0] ? entries_reg[0] : push_value;
        for (int i = 1; i < DEPTH; i++)
        begin
            if (keep[i])
            begin
                entries_next[i] = entries_reg[i];
            end
            else if (keep[i-1])
            begin
                entries_next[i] = push_value;
            end
            else
            begin
                entries_next[i] = entries_reg[i-1];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        popped_next = '0;
        if (cmd.do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.do_pop)
        begin
            count_next  = count_dec;
            popped_next = entries_reg[pop_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
        if (cmd.load)
        begin
            popped_reg <= popped_next;
            status_reg <= cmd.code;
            fill_reg   <= FILL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign fill_count   = fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count past depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not add an entry");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not remove an entry");

endmodule
